### rtl/vsp_pkg.sv
package vsp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SHIFT     = 2 * FRAC_BITS;

  localparam int AXES    = 3;
  localparam int AXIS_W  = 2;
  localparam int VEL_W   = 27;
  localparam int ERR_W   = VEL_W + 1;
  localparam int GAIN_W  = 25;
  localparam int MASS_W  = 31;
  localparam int WORD_W  = 32;
  localparam int LIMIT_W = 64;
  localparam int CFG_W   = 64;
  localparam int IDX_W   = 3;

  // shared multiplier: 33 x 32 signed
  localparam int OPA_W  = 33;
  localparam int OPB_W  = 32;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int HALF_W = 32;
  localparam int ACC_W  = 96;

  localparam int STEP_W     = 4;
  localparam int UCODE_LEN  = 9;

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_P  = 3'd0,
    REG_GAIN_I  = 3'd1,
    REG_GAIN_D  = 3'd2,
    REG_LIMIT_X = 3'd3,
    REG_LIMIT_Y = 3'd4,
    REG_LIMIT_Z = 3'd5,
    REG_AXIS_EN = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_P,
    MUL_I,
    MUL_D,
    MUL_MLO,
    MUL_MHI
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_HI
  } acc_op_t;

  typedef enum logic {
    JMP_NEXT,
    JMP_AXIS
  } jmp_t;

  typedef struct packed {
    logic     prep;
    mul_sel_t mul;
    acc_op_t  acc;
    logic     save_hi;
    logic     finish;
    jmp_t     jmp;
  } ucw_t;

  typedef struct packed {
    logic              load;
    logic              run;
    logic [AXIS_W-1:0] axis;
    ucw_t              uw;
  } dp_ctrl_t;

  localparam ucw_t UCW_NOP = '{prep: 1'b0, mul: MUL_NONE, acc: ACC_HOLD,
                               save_hi: 1'b0, finish: 1'b0, jmp: JMP_NEXT};

  // per-axis program; the product register sits between multiply and accumulate,
  // so each accumulate step consumes the product issued by the step before it
  function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
    ucw_t w;
    w = UCW_NOP;
    case (step)
      4'd0: w.prep = 1'b1;
      4'd1: w.mul = MUL_P;
      4'd2: begin
        w.mul = MUL_I;
        w.acc = ACC_LOAD;
      end
      4'd3: begin
        w.mul = MUL_D;
        w.acc = ACC_ADD;
      end
      4'd4: w.acc = ACC_ADD;
      4'd5: begin
        w.mul     = MUL_MLO;
        w.save_hi = 1'b1;
      end
      4'd6: begin
        w.mul = MUL_MHI;
        w.acc = ACC_LOAD;
      end
      4'd7: w.acc = ACC_ADD_HI;
      4'd8: begin
        w.finish = 1'b1;
        w.jmp    = JMP_AXIS;
      end
      default: w = UCW_NOP;
    endcase
    return w;
  endfunction

endpackage

### rtl/vsp_sequencer.sv
module vsp_sequencer
  import vsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     run,
  input  logic     out_free,
  output logic     in_stall,
  output logic     push,
  output dp_ctrl_t ctrl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t              state;
  logic [STEP_W-1:0]   step;
  logic [AXIS_W-1:0]   axis;
  ucw_t                uw;
  logic                accept;

  always_comb begin
    uw        = (state == S_RUN) ? ucode(step) : UCW_NOP;
    accept    = (state == S_IDLE) && in_valid;
    push      = (state == S_DONE) && out_free;
    in_stall  = (state != S_IDLE);
    ctrl.load = accept;
    ctrl.run  = run;
    ctrl.axis = axis;
    ctrl.uw   = uw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      axis  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            step  <= '0;
            axis  <= '0;
            state <= run ? S_RUN : S_DONE;
          end
        end
        S_RUN: begin
          if (uw.jmp == JMP_AXIS) begin
            step <= '0;
            if (axis == AXIS_W'(AXES - 1)) begin
              state <= S_DONE;
            end else begin
              axis <= axis + 1'b1;
            end
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // inactive or zero-mass requests skip the program
  a_bypass: assert property (@(posedge clk) disable iff (rst)
    accept && !run |=> state == S_DONE)
    else $error("bypass request did not go straight to done");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> step < STEP_W'(UCODE_LEN) && axis < AXIS_W'(AXES))
    else $error("step or axis counter out of range");

  a_last_axis: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN && uw.finish && axis == AXIS_W'(AXES - 1) |=> state == S_DONE)
    else $error("program did not end after last axis");

endmodule

### rtl/vsp_datapath.sv
module vsp_datapath
  import vsp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  dp_ctrl_t                  ctrl,
  input  logic                      active,
  input  logic signed [VEL_W-1:0]   meas_vel_x,
  input  logic signed [VEL_W-1:0]   meas_vel_y,
  input  logic signed [VEL_W-1:0]   meas_vel_z,
  input  logic signed [VEL_W-1:0]   target_vel_x,
  input  logic signed [VEL_W-1:0]   target_vel_y,
  input  logic signed [VEL_W-1:0]   target_vel_z,
  input  logic        [MASS_W-1:0]  body_mass,
  input  logic signed [GAIN_W-1:0]  gain_p,
  input  logic signed [GAIN_W-1:0]  gain_i,
  input  logic signed [GAIN_W-1:0]  gain_d,
  input  logic        [LIMIT_W-1:0] limit_x,
  input  logic        [LIMIT_W-1:0] limit_y,
  input  logic        [LIMIT_W-1:0] limit_z,
  input  logic        [AXES-1:0]    limit_axis_enable,
  output logic signed [WORD_W-1:0]  force_x,
  output logic signed [WORD_W-1:0]  force_y,
  output logic signed [WORD_W-1:0]  force_z,
  output logic                      force_valid
);

  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  logic signed [VEL_W-1:0]   meas [AXES];
  logic signed [VEL_W-1:0]   tgt  [AXES];
  logic        [MASS_W-1:0]  mass;
  logic signed [WORD_W-1:0]  prev_err [AXES];
  logic signed [WORD_W-1:0]  err_int  [AXES];
  logic signed [WORD_W-1:0]  force_r  [AXES];
  logic                      valid_r;

  logic signed [ERR_W-1:0]   e_r;
  logic signed [OPA_W-1:0]   dv_r;
  logic signed [WORD_W-1:0]  integ_r;
  logic signed [WORD_W-1:0]  sum_hi;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;

  logic signed [ERR_W-1:0]   e_now;
  logic signed [OPA_W-1:0]   dv_now;
  logic signed [WORD_W:0]    isum;
  logic signed [WORD_W-1:0]  integ_now;
  logic signed [OPA_W-1:0]   opa;
  logic signed [OPB_W-1:0]   opb;
  logic signed [PROD_W-1:0]  mul_out;
  logic signed [ACC_W-1:0]   acc_sh;
  logic signed [WORD_W-1:0]  f_sat;
  logic signed [WORD_W-1:0]  f_final;
  logic signed [WORD_W-1:0]  integ_final;
  logic        [LIMIT_W-1:0] limit_sel;
  logic signed [WORD_W-1:0]  upper;
  logic signed [WORD_W-1:0]  lower;
  logic                      clamp_en;
  logic                      hi_clip;
  logic                      lo_clip;
  logic [ACC_W-WORD_W:0]     acc_top;

  always_comb begin
    e_now  = ERR_W'(tgt[ctrl.axis]) - ERR_W'(meas[ctrl.axis]);
    dv_now = OPA_W'(e_now) - OPA_W'(prev_err[ctrl.axis]);
    isum   = (WORD_W+1)'(err_int[ctrl.axis]) + (WORD_W+1)'(e_now);
    if (isum[WORD_W] != isum[WORD_W-1]) begin
      integ_now = isum[WORD_W] ? WORD_MIN : WORD_MAX;
    end else begin
      integ_now = isum[WORD_W-1:0];
    end
  end

  // operand pairing is fixed by the multiply select
  always_comb begin
    case (ctrl.uw.mul)
      MUL_P: begin
        opa = OPA_W'(e_r);
        opb = OPB_W'(gain_p);
      end
      MUL_I: begin
        opa = OPA_W'(integ_r);
        opb = OPB_W'(gain_i);
      end
      MUL_D: begin
        opa = dv_r;
        opb = OPB_W'(gain_d);
      end
      MUL_MLO: begin
        opa = $signed({1'b0, acc[HALF_W-1:0]});
        opb = $signed({1'b0, mass});
      end
      MUL_MHI: begin
        opa = OPA_W'(sum_hi);
        opb = $signed({1'b0, mass});
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign mul_out = opa * opb;

  // arithmetic shift floors the exact product
  always_comb begin
    acc_sh  = acc >>> SHIFT;
    acc_top = acc_sh[ACC_W-1:WORD_W-1];
    if ((&acc_top) || !(|acc_top)) begin
      f_sat = acc_sh[WORD_W-1:0];
    end else begin
      f_sat = acc_sh[ACC_W-1] ? WORD_MIN : WORD_MAX;
    end

    case (ctrl.axis)
      2'd0:    limit_sel = limit_x;
      2'd1:    limit_sel = limit_y;
      default: limit_sel = limit_z;
    endcase
    upper    = $signed(limit_sel[LIMIT_W-1:WORD_W]);
    lower    = $signed(limit_sel[WORD_W-1:0]);
    clamp_en = limit_axis_enable[ctrl.axis];
    hi_clip  = clamp_en && (f_sat > upper);
    lo_clip  = clamp_en && !hi_clip && (f_sat < lower);

    if (hi_clip) begin
      f_final = upper;
    end else if (lo_clip) begin
      f_final = lower;
    end else begin
      f_final = f_sat;
    end
    // anti-windup: keep the old integral when the force clamps
    integ_final = (hi_clip || lo_clip) ? err_int[ctrl.axis] : integ_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        prev_err[a] <= '0;
        err_int[a]  <= '0;
      end
      valid_r <= 1'b0;
    end else begin
      if (ctrl.load) begin
        valid_r <= ctrl.run;
        if (!active) begin
          for (int a = 0; a < AXES; a++) begin
            prev_err[a] <= '0;
            err_int[a]  <= '0;
          end
        end
      end
      if (ctrl.uw.finish) begin
        prev_err[ctrl.axis] <= WORD_W'(e_r);
        err_int[ctrl.axis]  <= integ_final;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      meas[0] <= meas_vel_x;
      meas[1] <= meas_vel_y;
      meas[2] <= meas_vel_z;
      tgt[0]  <= target_vel_x;
      tgt[1]  <= target_vel_y;
      tgt[2]  <= target_vel_z;
      mass    <= body_mass;
      if (!ctrl.run) begin
        for (int a = 0; a < AXES; a++) begin
          force_r[a] <= '0;
        end
      end
    end
    if (ctrl.uw.prep) begin
      e_r     <= e_now;
      dv_r    <= dv_now;
      integ_r <= integ_now;
    end
    if (ctrl.uw.mul != MUL_NONE) begin
      prod <= mul_out;
    end
    if (ctrl.uw.save_hi) begin
      sum_hi <= acc[2*HALF_W-1:HALF_W];
    end
    case (ctrl.uw.acc)
      ACC_LOAD:   acc <= ACC_W'(prod);
      ACC_ADD:    acc <= acc + ACC_W'(prod);
      ACC_ADD_HI: acc <= acc + (ACC_W'(prod) <<< HALF_W);
      default:    acc <= acc;
    endcase
    if (ctrl.uw.finish) begin
      force_r[ctrl.axis] <= f_final;
    end
  end

  assign force_x     = force_r[0];
  assign force_y     = force_r[1];
  assign force_z     = force_r[2];
  assign force_valid = valid_r;

endmodule

### rtl/velocity_servo_pid_3axis_core.sv
// Three-axis velocity PID servo with per-axis force clamp and anti-windup. A request
// with active high and nonzero mass runs a nine-step microprogram per axis on one
// shared 33x32 multiplier (three gain products, then the 64-bit PID sum times the
// mass in two halves); the input stalls from acceptance until the result is handed to
// the output register, so a new request is not taken while one is in the program.
// Inactive or zero-mass requests skip the program. The output register frees the input
// side while a result waits. The user must write configuration through write_en/
// reg_index/write_data only while idle; the block itself does not enforce this.
module velocity_servo_pid_3axis_core
  import vsp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     write_en,
  input  logic        [IDX_W-1:0]  reg_index,
  input  logic        [CFG_W-1:0]  write_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     active,
  input  logic signed [VEL_W-1:0]  meas_vel_x,
  input  logic signed [VEL_W-1:0]  meas_vel_y,
  input  logic signed [VEL_W-1:0]  meas_vel_z,
  input  logic signed [VEL_W-1:0]  target_vel_x,
  input  logic signed [VEL_W-1:0]  target_vel_y,
  input  logic signed [VEL_W-1:0]  target_vel_z,
  input  logic        [MASS_W-1:0] body_mass,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] force_x,
  output logic signed [WORD_W-1:0] force_y,
  output logic signed [WORD_W-1:0] force_z,
  output logic                     force_valid
);

  logic signed [GAIN_W-1:0]  gain_p;
  logic signed [GAIN_W-1:0]  gain_i;
  logic signed [GAIN_W-1:0]  gain_d;
  logic        [LIMIT_W-1:0] limit_x;
  logic        [LIMIT_W-1:0] limit_y;
  logic        [LIMIT_W-1:0] limit_z;
  logic        [AXES-1:0]    limit_axis_enable;

  dp_ctrl_t                  ctrl;
  logic                      run;
  logic                      push;
  logic                      out_free;
  logic signed [WORD_W-1:0]  dp_force_x;
  logic signed [WORD_W-1:0]  dp_force_y;
  logic signed [WORD_W-1:0]  dp_force_z;
  logic                      dp_force_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p            <= '0;
      gain_i            <= '0;
      gain_d            <= '0;
      limit_x           <= '0;
      limit_y           <= '0;
      limit_z           <= '0;
      limit_axis_enable <= '0;
    end else if (write_en) begin
      case (reg_idx_t'(reg_index))
        REG_GAIN_P:  gain_p            <= write_data[GAIN_W-1:0];
        REG_GAIN_I:  gain_i            <= write_data[GAIN_W-1:0];
        REG_GAIN_D:  gain_d            <= write_data[GAIN_W-1:0];
        REG_LIMIT_X: limit_x           <= write_data;
        REG_LIMIT_Y: limit_y           <= write_data;
        REG_LIMIT_Z: limit_z           <= write_data;
        REG_AXIS_EN: limit_axis_enable <= write_data[AXES-1:0];
        default: ;
      endcase
    end
  end

  assign run      = active && (body_mass != '0);
  assign out_free = !out_valid || !out_stall;

  vsp_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .run      (run),
    .out_free (out_free),
    .in_stall (in_stall),
    .push     (push),
    .ctrl     (ctrl)
  );

  vsp_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .ctrl              (ctrl),
    .active            (active),
    .meas_vel_x        (meas_vel_x),
    .meas_vel_y        (meas_vel_y),
    .meas_vel_z        (meas_vel_z),
    .target_vel_x      (target_vel_x),
    .target_vel_y      (target_vel_y),
    .target_vel_z      (target_vel_z),
    .body_mass         (body_mass),
    .gain_p            (gain_p),
    .gain_i            (gain_i),
    .gain_d            (gain_d),
    .limit_x           (limit_x),
    .limit_y           (limit_y),
    .limit_z           (limit_z),
    .limit_axis_enable (limit_axis_enable),
    .force_x           (dp_force_x),
    .force_y           (dp_force_y),
    .force_z           (dp_force_z),
    .force_valid       (dp_force_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      force_x     <= dp_force_x;
      force_y     <= dp_force_y;
      force_z     <= dp_force_z;
      force_valid <= dp_force_valid;
    end
  end

  // a finished result never overwrites one still waiting downstream
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    push |-> !(out_valid && out_stall))
    else $error("result pushed over a stalled result");

endmodule

### verif/velocity_servo_pid_3axis_core_test.sv
module velocity_servo_pid_3axis_core_test
  import vsp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE = 1 << FRAC_BITS;
  localparam int VEL_MAX = 65536000;
  localparam int GAIN_MIN = -6553600;
  localparam int GAIN_MAX = 13107200;
  localparam logic [MASS_W-1:0] MASS_MAX = {MASS_W{1'b1}};
  localparam longint WORD_MAX = 64'sh7FFF_FFFF;
  localparam longint WORD_MIN = -64'sh8000_0000;
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic                         active;
    logic [AXES-1:0][VEL_W-1:0]   meas;
    logic [AXES-1:0][VEL_W-1:0]   tgt;
    logic [MASS_W-1:0]            mass;
  } servo_req_t;

  typedef struct packed {
    logic [AXES-1:0][WORD_W-1:0] frc;
    logic                        fv;
  } force_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic write_en = 1'b0;
  logic [IDX_W-1:0] reg_index = '0;
  logic [CFG_W-1:0] write_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic active = 1'b0;
  logic signed [VEL_W-1:0] meas_vel_x = '0, meas_vel_y = '0, meas_vel_z = '0;
  logic signed [VEL_W-1:0] target_vel_x = '0, target_vel_y = '0, target_vel_z = '0;
  logic [MASS_W-1:0] body_mass = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [WORD_W-1:0] force_x, force_y, force_z;
  logic force_valid;

  velocity_servo_pid_3axis_core DUT (
    .clk, .rst, .write_en, .reg_index, .write_data,
    .in_valid, .in_stall, .active,
    .meas_vel_x, .meas_vel_y, .meas_vel_z,
    .target_vel_x, .target_vel_y, .target_vel_z,
    .body_mass, .out_valid, .out_stall,
    .force_x, .force_y, .force_z, .force_valid
  );

  always #4 clk = ~clk;

  // servo copy: configuration and per-axis state
  longint gain_cfg [3] = '{0, 0, 0};
  logic [LIMIT_W-1:0] limit_cfg [AXES] = '{0, 0, 0};
  logic [AXES-1:0] clamp_en_cfg = '0;
  logic signed [WORD_W-1:0] prev_err [AXES] = '{0, 0, 0};
  logic signed [WORD_W-1:0] err_sum [AXES] = '{0, 0, 0};

  servo_req_t request_q [$];
  force_res_t force_q [$];
  servo_req_t on_port;
  int gap_max = 6;
  int stall_max = 6;
  int err_count = 0;
  int results_seen = 0;

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic force_res_t predict_force(input servo_req_t r);
    force_res_t res;
    longint e, dv, isum, pid, f;
    logic signed [127:0] wide, mw, q;
    logic signed [WORD_W-1:0] up, lo;
    int a;
    res = '0;
    if (!r.active) begin
      for (a = 0; a < AXES; a++) begin
        prev_err[a] = '0;
        err_sum[a] = '0;
      end
      return res;
    end
    if (r.mass == '0) return res;
    for (a = 0; a < AXES; a++) begin
      e = longint'($signed(r.tgt[a])) - longint'($signed(r.meas[a]));
      dv = e - longint'(prev_err[a]);
      isum = longint'(err_sum[a]) + e;
      if (isum > WORD_MAX) isum = WORD_MAX;
      else if (isum < WORD_MIN) isum = WORD_MIN;
      pid = gain_cfg[0] * e + gain_cfg[1] * isum + gain_cfg[2] * dv;
      wide = pid;
      mw = {97'd0, r.mass};
      // floor division by 2^(2*frac) comes from the arithmetic shift
      q = (wide * mw) >>> (2 * FRAC_BITS);
      if (q > WORD_MAX) f = WORD_MAX;
      else if (q < WORD_MIN) f = WORD_MIN;
      else f = q[63:0];
      if (clamp_en_cfg[a]) begin
        up = limit_cfg[a][63:32];
        lo = limit_cfg[a][31:0];
        // upper test first, so inverted bounds resolve to upper when above it
        if (f > up) begin
          f = up;
          isum = err_sum[a];
        end else if (f < lo) begin
          f = lo;
          isum = err_sum[a];
        end
      end
      prev_err[a] = e[31:0];
      err_sum[a] = isum[31:0];
      res.frc[a] = f[31:0];
    end
    res.fv = 1'b1;
    return res;
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    @(posedge clk);
    write_en <= 1'b1;
    reg_index <= idx;
    write_data <= v;
    case (idx)
      REG_GAIN_P:  gain_cfg[0] = longint'($signed(v[GAIN_W-1:0]));
      REG_GAIN_I:  gain_cfg[1] = longint'($signed(v[GAIN_W-1:0]));
      REG_GAIN_D:  gain_cfg[2] = longint'($signed(v[GAIN_W-1:0]));
      REG_LIMIT_X: limit_cfg[0] = v;
      REG_LIMIT_Y: limit_cfg[1] = v;
      REG_LIMIT_Z: limit_cfg[2] = v;
      REG_AXIS_EN: clamp_en_cfg = v[AXES-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    write_en <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (request_q.size() != 0 || in_valid || force_q.size() != 0);
  endtask

  function automatic logic [CFG_W-1:0] bounds(input int up, input int lo);
    return {up, lo};
  endfunction

  task automatic queue_req(input logic act, input int mx, input int my, input int mz,
                           input int tx, input int ty, input int tz,
                           input logic [MASS_W-1:0] m);
    servo_req_t r;
    r.active = act;
    r.meas = {VEL_W'(mz), VEL_W'(my), VEL_W'(mx)};
    r.tgt = {VEL_W'(tz), VEL_W'(ty), VEL_W'(tx)};
    r.mass = m;
    request_q.push_back(r);
  endtask

  function automatic int rand_vel();
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 2 * VEL_MAX)) - VEL_MAX;
      1: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
      2: return $urandom_range(0, 1) ? VEL_MAX : -VEL_MAX;
      default: return int'($urandom_range(0, 1 << 23)) - (1 << 22);
    endcase
  endfunction

  function automatic logic [MASS_W-1:0] rand_mass();
    case ($urandom_range(0, 3))
      0: return MASS_W'($urandom_range(1, 4 * ONE));
      1: return MASS_W'($urandom);
      2: return MASS_MAX;
      default: return MASS_W'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_gain();
    logic [CFG_W-1:0] v;
    int g;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: g = $urandom_range(0, 1) ? GAIN_MAX : GAIN_MIN;
      1: g = int'($urandom_range(0, GAIN_MAX - GAIN_MIN)) + GAIN_MIN;
      2: g = int'($urandom_range(0, 4 * ONE)) - 2 * ONE;
      default: g = $urandom_range(0, ONE);
    endcase
    // bits above the gain width are don't-care
    v[GAIN_W-1:0] = g[GAIN_W-1:0];
    return v;
  endfunction

  function automatic logic [CFG_W-1:0] rand_limit();
    int up, lo;
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: begin
        up = $urandom_range(0, 50 * ONE);
        lo = -int'($urandom_range(0, 50 * ONE));
      end
      2: begin
        lo = $urandom_range(0, 20 * ONE);
        up = -int'($urandom_range(0, 20 * ONE));
      end
      default: begin
        up = $urandom_range(0, ONE);
        lo = -int'($urandom_range(0, ONE));
      end
    endcase
    return bounds(up, lo);
  endfunction

  function automatic servo_req_t rand_req(input bit windup, input bit wind_neg);
    servo_req_t r;
    int a, k, v;
    k = $urandom_range(0, 99);
    r.active = windup || k >= 8;
    r.mass = (!windup && k >= 8 && k < 15) ? '0 : rand_mass();
    for (a = 0; a < AXES; a++) begin
      if (windup) begin
        v = VEL_MAX - int'($urandom_range(0, 1 << 16));
        r.meas[a] = wind_neg ? VEL_W'(v) : VEL_W'(-v);
        r.tgt[a] = wind_neg ? VEL_W'(-v) : VEL_W'(v);
      end else begin
        r.meas[a] = VEL_W'(rand_vel());
        r.tgt[a] = VEL_W'(rand_vel());
      end
    end
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin : driver
    int gap_left;
    bit busy;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        force_q.push_back(predict_force(on_port));
        gap_left = $urandom_range(0, gap_max);
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          on_port = request_q.pop_front();
          active <= on_port.active;
          meas_vel_x <= on_port.meas[0];
          meas_vel_y <= on_port.meas[1];
          meas_vel_z <= on_port.meas[2];
          target_vel_x <= on_port.tgt[0];
          target_vel_y <= on_port.tgt[1];
          target_vel_z <= on_port.tgt[2];
          body_mass <= on_port.mass;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // force monitor and receiver stall
  always @(posedge clk) begin : monitor
    logic [AXES-1:0][WORD_W-1:0] got;
    force_res_t want;
    int stall_left, hold_left, a;
    bit hold_done;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {force_z, force_y, force_x};
        if (force_q.size() == 0) begin
          flag_mismatch("force result with no request pending");
        end else begin
          want = force_q.pop_front();
          for (a = 0; a < AXES; a++) begin
            if (got[a] !== want.frc[a])
              flag_mismatch($sformatf("force axis %0d: got %0d want %0d", a,
                                      $signed(got[a]), $signed(want.frc[a])));
          end
          if (force_valid !== want.fv)
            flag_mismatch($sformatf("force_valid: got %b want %b", force_valid, want.fv));
        end
        results_seen++;
        stall_left = $urandom_range(0, stall_max);
        // one long hold-off while the sender still has plenty queued
        if (!hold_done && results_seen >= 240 && request_q.size() > 8) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end else if (stall_left > 0) begin
        stall_left--;
      end
      if (hold_left > 0) hold_left--;
      out_stall <= (stall_left > 0) || (hold_left > 0);
    end
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int ph, i, n_wind;
    bit wind_neg;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset configuration: zero gains give zero force but a valid result
    queue_req(1'b1, -VEL_MAX, -VEL_MAX, -VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX, MASS_MAX);
    queue_req(1'b1, VEL_MAX, 0, -VEL_MAX, -VEL_MAX, 0, VEL_MAX, 1);
    wait_drained();

    // moderate gains, y bounds inverted, z bounds at the word extremes
    write_reg(REG_GAIN_P, CFG_W'(ONE));
    write_reg(REG_GAIN_I, CFG_W'(ONE / 2));
    write_reg(REG_GAIN_D, CFG_W'(ONE / 4));
    write_reg(REG_LIMIT_X, bounds(10 * ONE, -10 * ONE));
    write_reg(REG_LIMIT_Y, bounds(-5 * ONE, 5 * ONE));
    write_reg(REG_LIMIT_Z, bounds(32'h7FFF_FFFF, 32'h8000_0000));
    write_reg(REG_AXIS_EN, CFG_W'(3'b111));
    write_reg(REG_UNUSED, '1);
    end_writes();
    queue_req(1'b1, ONE, -ONE, 2 * ONE, 3 * ONE, ONE, 0, ONE);
    queue_req(1'b1, ONE, -ONE, 2 * ONE, 3 * ONE, ONE, 0, ONE);
    queue_req(1'b1, -VEL_MAX, -VEL_MAX, -VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX, ONE);
    queue_req(1'b1, VEL_MAX, VEL_MAX, VEL_MAX, -VEL_MAX, -VEL_MAX, -VEL_MAX, ONE);
    queue_req(1'b0, VEL_MAX, -VEL_MAX, 123, -VEL_MAX, VEL_MAX, -77, MASS_MAX);
    queue_req(1'b1, 0, ONE, -ONE, ONE, 0, ONE, 2 * ONE);
    queue_req(1'b0 ^ 1'b1, -VEL_MAX, VEL_MAX, 0, VEL_MAX, -VEL_MAX, 5, 0);
    queue_req(1'b1, VEL_MAX, -VEL_MAX, VEL_MAX, -VEL_MAX, VEL_MAX, -VEL_MAX, MASS_MAX);
    queue_req(1'b1, 1, -1, 3, 0, 0, 0, 1);
    queue_req(1'b1, 1, 0, -1, 0, 1, 0, ONE);
    wait_drained();

    // largest gains, no clamp: force saturates both ways
    write_reg(REG_GAIN_P, CFG_W'(GAIN_MAX));
    write_reg(REG_GAIN_I, CFG_W'(GAIN_MAX));
    write_reg(REG_GAIN_D, CFG_W'(GAIN_MAX));
    write_reg(REG_AXIS_EN, '0);
    end_writes();
    queue_req(1'b1, -VEL_MAX, -VEL_MAX, -VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX, MASS_MAX);
    queue_req(1'b1, VEL_MAX, VEL_MAX, VEL_MAX, -VEL_MAX, -VEL_MAX, -VEL_MAX, MASS_MAX);
    queue_req(1'b1, 7, -7, 0, 7, -7, 0, 3);
    wait_drained();

    // most negative gains, clamp to zero on x
    write_reg(REG_GAIN_P, CFG_W'(GAIN_MIN));
    write_reg(REG_GAIN_I, CFG_W'(GAIN_MIN));
    write_reg(REG_GAIN_D, CFG_W'(GAIN_MIN));
    write_reg(REG_LIMIT_X, '0);
    write_reg(REG_LIMIT_Y, bounds(32'h7FFF_FFFF, 32'h8000_0000));
    write_reg(REG_LIMIT_Z, bounds(ONE, -ONE));
    write_reg(REG_AXIS_EN, CFG_W'(3'b111));
    end_writes();
    queue_req(1'b1, -VEL_MAX, -VEL_MAX, -VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX, MASS_MAX);
    queue_req(1'b1, VEL_MAX, VEL_MAX, VEL_MAX, -VEL_MAX, -VEL_MAX, -VEL_MAX, MASS_MAX);
    queue_req(1'b1, 100, -100, 50, -100, 100, -50, ONE);
    queue_req(1'b0, 0, 0, 0, 0, 0, 0, 0);
    wait_drained();

    for (ph = 0; ph < 8; ph++) begin
      gap_max = (ph % 4 == 0) ? 0 : 6;
      stall_max = (ph % 4 == 0 || ph % 4 == 3) ? 0 : 6;
      write_reg(REG_GAIN_P, rand_gain());
      write_reg(REG_GAIN_I, rand_gain());
      write_reg(REG_GAIN_D, rand_gain());
      write_reg(REG_LIMIT_X, rand_limit());
      write_reg(REG_LIMIT_Y, rand_limit());
      write_reg(REG_LIMIT_Z, rand_limit());
      write_reg(REG_AXIS_EN, {$urandom, $urandom});
      if ($urandom_range(0, 1)) write_reg(REG_UNUSED, {$urandom, $urandom});
      end_writes();
      // a run of same-sign large errors drives the integral into saturation
      n_wind = $urandom_range(0, 1) ? 20 : 0;
      wind_neg = $urandom_range(0, 1);
      for (i = 0; i < 54; i++) request_q.push_back(rand_req(i < n_wind, wind_neg));
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (force_q.size() != 0)
      flag_mismatch($sformatf("%0d force results never arrived", force_q.size()));
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
